FILE: rtl/srrw_pkg.sv
package srrw_pkg;

  localparam int SLOTS       = 64;
  localparam int IDX_W       = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int PAYLOAD_MAX = 512;
  localparam int MAX_RES     = 34;
  localparam int RES_W       = $clog2(MAX_RES);

  // operation codes
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // decode status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_OTHER    = 2'd2;

  // packet types
  localparam logic [1:0] PT_DATA = 2'd0;

  // result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_NACK    = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;

  // configuration register indexes
  localparam logic REG_MAX_WINDOW  = 1'b0;
  localparam logic REG_HALVE_ABOVE = 1'b1;

  typedef struct packed {
    logic [31:0] send_time;
    logic [9:0]  length;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic        operation;
    logic [1:0]  decode_status;
    logic [1:0]  packet_type;
    logic        truncated;
    logic [7:0]  seq_in;
    logic [9:0]  payload_length;
    logic [31:0] send_time;
    logic [15:0] payload_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  seq_out;
    logic [4:0]  window_out;
    logic [31:0] time_out;
    logic [15:0] tag_out;
    logic [9:0]  length_out;
    logic        finished;
    logic        last;
  } res_t;

endpackage

FILE: rtl/srrw_in_if.sv
interface srrw_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [1:0]  decode_status;
  logic [1:0]  packet_type;
  logic        truncated;
  logic [7:0]  seq_in;
  logic [9:0]  payload_length;
  logic [31:0] send_time;
  logic [15:0] payload_tag;

  modport source (output valid, operation, decode_status, packet_type, truncated, seq_in,
                  payload_length, send_time, payload_tag, input ready);
  modport sink (input valid, operation, decode_status, packet_type, truncated, seq_in,
                payload_length, send_time, payload_tag, output ready);
endinterface

FILE: rtl/srrw_out_if.sv
interface srrw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  seq_out;
  logic [4:0]  window_out;
  logic [31:0] time_out;
  logic [15:0] tag_out;
  logic [9:0]  length_out;
  logic        finished;
  logic        last;

  modport source (output valid, kind, seq_out, window_out, time_out, tag_out, length_out,
                  finished, last, input ready);
  modport sink (input valid, kind, seq_out, window_out, time_out, tag_out, length_out,
                finished, last, output ready);
endinterface

FILE: rtl/selective_repeat_receive_window.sv
// channel  | dir | handshake         | carries
// in_ch    | in  | valid / ready     | packet header request or send tick
// out_ch   | out | valid / ready     | ack, nack or in-order delivery
// cfg      | in  | cfg_we            | max_window, halve_above
//
// a tick passes through evaluate, finish and idle between one accepted request and the next.
// a packet passes through evaluate, walk, finish and idle, with a walk and a data step per
// delivered entry; a nack adds a nack step, and a halving nack adds trimming steps first.
// the delivery walk reads the reorder memory one entry at a time, in a walk then a data step.
// reset clears all control state and the valid bits.
// a stalled output holds the walk; in_ch.ready is high only between requests.
module selective_repeat_receive_window
  import srrw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  srrw_in_if.sink     in_ch,
  srrw_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_TRIM  = 3'd2;
  localparam logic [2:0] S_NACK  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_WDATA = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]       state_r;
  logic [4:0]       max_window_r;
  logic [4:0]       halve_above_r;
  logic [7:0]       head_r;
  logic [4:0]       window_r;
  logic             ack_pending_r;
  logic             eof_seen_r;
  logic [7:0]       eof_seq_r;
  logic [31:0]      last_time_r;
  logic             done_r;
  logic [SLOTS-1:0] valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] trim_r;
  logic [RES_W-1:0] nres_r;
  req_t             req_r;
  res_t             pend_r;
  logic             pend_v_r;
  res_t             out_r;
  logic             out_valid_r;

  // reorder memory
  logic [57:0]      mem [SLOTS];
  logic [57:0]      rd_data_r;
  entry_t           rd_entry;
  logic             mem_we;
  logic [IDX_W-1:0] mem_widx;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_widx] <= {req_r.send_time, req_r.payload_length, req_r.payload_tag};
    end
    rd_data_r <= mem[head_r[IDX_W-1:0]];
  end
  assign rd_entry = entry_t'(rd_data_r);

  // request decode
  logic [1:0]       status;
  logic [7:0]       seq_offset;
  logic             in_win;
  logic             eof_block;
  logic             do_nack;
  logic             do_store;
  logic [IDX_W-1:0] seq_idx;
  logic [IDX_W-1:0] head_idx;
  logic [IDX_W-1:0] trim_idx;
  logic [7:0]       head_inc;

  always_comb begin
    status     = (req_r.payload_length > 10'(PAYLOAD_MAX)) ? ST_OTHER : req_r.decode_status;
    seq_offset = req_r.seq_in - head_r;
    in_win     = (window_r == 5'd0) ? (seq_offset == 8'd0) :
                 (seq_offset <= ({3'd0, window_r} + 8'd1));
    eof_block  = eof_seen_r && (head_r == eof_seq_r);
    do_nack    = 1'b0;
    do_store   = 1'b0;
    if (!eof_block) begin
      if (status == ST_CHECKSUM) begin
        do_nack = (req_r.packet_type == PT_DATA) && req_r.truncated && in_win;
      end else if (status == ST_OK && req_r.packet_type == PT_DATA) begin
        do_nack  = req_r.truncated;
        do_store = !req_r.truncated && in_win;
      end
    end
    seq_idx  = req_r.seq_in[IDX_W-1:0];
    head_idx = head_r[IDX_W-1:0];
    trim_idx = head_idx + trim_r[IDX_W-1:0] - IDX_W'(1);
    head_inc = head_r + 8'd1;
  end

  assign mem_we   = (state_r == S_EVAL) && !done_r && (req_r.operation == OP_PACKET) &&
                    do_store && !valid_r[seq_idx];
  assign mem_widx = seq_idx;

  // result production
  logic out_free;
  logic emit_req;
  logic emit_go;
  res_t emit_val;

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    emit_req = 1'b0;
    emit_val = '0;
    case (state_r)
      S_EVAL: begin
        if (!done_r && req_r.operation == OP_TICK && ack_pending_r) begin
          emit_req            = 1'b1;
          emit_val.kind       = KIND_ACK;
          emit_val.seq_out    = head_r;
          emit_val.window_out = window_r;
          emit_val.time_out   = last_time_r;
        end
      end
      S_NACK: begin
        emit_req            = 1'b1;
        emit_val.kind       = KIND_NACK;
        emit_val.seq_out    = req_r.seq_in;
        emit_val.window_out = window_r;
        emit_val.time_out   = req_r.send_time;
      end
      S_WDATA: begin
        emit_req = 1'b1;
        if (rd_entry.length == 10'd0) begin
          emit_val.kind       = KIND_ACK;
          emit_val.seq_out    = head_inc;
          emit_val.window_out = window_r;
          emit_val.time_out   = rd_entry.send_time;
          emit_val.finished   = 1'b1;
        end else begin
          emit_val.kind       = KIND_DELIVER;
          emit_val.seq_out    = head_r;
          emit_val.tag_out    = rd_entry.tag;
          emit_val.length_out = rd_entry.length;
        end
      end
      default: begin
        emit_req = 1'b0;
      end
    endcase
    emit_go = emit_req && (!pend_v_r || out_free);
  end

  logic fin_go;
  logic out_load;
  res_t out_nxt;

  assign fin_go   = (state_r == S_FIN) && pend_v_r && out_free;
  assign out_load = (emit_go && pend_v_r) || fin_go;

  always_comb begin
    out_nxt      = pend_r;
    out_nxt.last = fin_go;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit_go) begin
        pend_v_r <= 1'b1;
      end else if (fin_go) begin
        pend_v_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (emit_go) begin
      pend_r <= emit_val;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_window_r  <= 5'd31;
      halve_above_r <= 5'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_WINDOW:  max_window_r  <= cfg_wdata;
        REG_HALVE_ABOVE: halve_above_r <= cfg_wdata;
        default:         max_window_r  <= max_window_r;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= 8'd0;
      window_r      <= 5'd1;
      ack_pending_r <= 1'b1;
      eof_seen_r    <= 1'b0;
      eof_seq_r     <= 8'd0;
      last_time_r   <= 32'd0;
      done_r        <= 1'b0;
      valid_r       <= '0;
      cnt_r         <= '0;
      trim_r        <= '0;
      nres_r        <= '0;
    end else begin
      if (emit_go) begin
        nres_r <= nres_r + RES_W'(1);
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_EVAL;
            nres_r  <= '0;
          end
        end
        S_EVAL: begin
          if (done_r) begin
            state_r <= S_IDLE;
          end else if (req_r.operation == OP_TICK) begin
            if (ack_pending_r) begin
              ack_pending_r <= 1'b0;
            end
            state_r <= S_FIN;
          end else begin
            state_r <= S_WALK;
            if (do_store) begin
              if (valid_r[seq_idx]) begin
                ack_pending_r <= 1'b1;
              end else begin
                valid_r[seq_idx] <= 1'b1;
                cnt_r            <= cnt_r + CNT_W'(1);
                if (req_r.payload_length == 10'd0) begin
                  eof_seen_r <= 1'b1;
                  eof_seq_r  <= req_r.seq_in;
                end
                if (head_r == req_r.seq_in) begin
                  if (window_r < max_window_r) begin
                    window_r <= window_r + 5'd1;
                  end
                  ack_pending_r <= 1'b0;
                end else begin
                  ack_pending_r <= 1'b1;
                end
              end
            end else if (!eof_block && status == ST_OK && req_r.packet_type == PT_DATA &&
                         !req_r.truncated) begin
              ack_pending_r <= 1'b1;
            end
            if (do_nack) begin
              if (window_r > halve_above_r) begin
                window_r   <= window_r >> 1;
                eof_seen_r <= 1'b0;
                trim_r     <= CNT_W'(SLOTS);
                state_r    <= S_TRIM;
              end else begin
                state_r <= S_NACK;
              end
            end
          end
        end
        S_TRIM: begin
          // drop farthest held entries until the count fits the window
          if (trim_r == '0 || cnt_r <= CNT_W'(window_r)) begin
            state_r <= S_NACK;
          end else begin
            if (valid_r[trim_idx]) begin
              valid_r[trim_idx] <= 1'b0;
              cnt_r             <= cnt_r - CNT_W'(1);
            end
            trim_r <= trim_r - CNT_W'(1);
          end
        end
        S_NACK: begin
          state_r <= S_WALK;
        end
        S_WALK: begin
          // the memory read of the head entry lands next cycle
          if (nres_r < RES_W'(MAX_RES - 1) && valid_r[head_idx]) begin
            state_r <= S_WDATA;
          end else begin
            if (cnt_r == '0) begin
              ack_pending_r <= 1'b1;
            end
            state_r <= S_FIN;
          end
        end
        S_WDATA: begin
          if (emit_go) begin
            valid_r[head_idx] <= 1'b0;
            cnt_r             <= cnt_r - CNT_W'(1);
            last_time_r       <= rd_entry.send_time;
            head_r            <= head_inc;
            if (rd_entry.length == 10'd0) begin
              done_r  <= 1'b1;
              state_r <= S_FIN;
            end else begin
              state_r <= S_WALK;
            end
          end
        end
        S_FIN: begin
          if (!pend_v_r || out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
    if (state_r == S_IDLE && in_ch.valid) begin
      req_r.operation      <= in_ch.operation;
      req_r.decode_status  <= in_ch.decode_status;
      req_r.packet_type    <= in_ch.packet_type;
      req_r.truncated      <= in_ch.truncated;
      req_r.seq_in         <= in_ch.seq_in;
      req_r.payload_length <= in_ch.payload_length;
      req_r.send_time      <= in_ch.send_time;
      req_r.payload_tag    <= in_ch.payload_tag;
    end
  end

  // ports
  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_r.kind;
  assign out_ch.seq_out    = out_r.seq_out;
  assign out_ch.window_out = out_r.window_out;
  assign out_ch.time_out   = out_r.time_out;
  assign out_ch.tag_out    = out_r.tag_out;
  assign out_ch.length_out = out_r.length_out;
  assign out_ch.finished   = out_r.finished;
  assign out_ch.last       = out_r.last;

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'($countones(valid_r)))
    else $error("held count differs from valid bits");
  a_ready_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !pend_v_r)
    else $error("request taken while a result is held back");
  a_eval_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $past(in_ch.valid && in_ch.ready))
    else $error("evaluation without an accepted request");
  a_done_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !mem_we)
    else $error("store written after transfer end");
`endif

endmodule
